[hdl/sfcrc_pkg.sv]
`default_nettype none

package sfcrc_pkg;

	// Reflected CRC-8, polynomial 0x31 in its shift-right form.
	localparam logic [7:0] CrcPoly = 8'h8C;

	// Position of the CRC byte in each frame kind.
	localparam logic [3:0] RomLast = 4'd7;
	localparam logic [3:0] PadLast = 4'd8;

	// Scratchpad byte positions that are kept.
	localparam logic [3:0] PadTempLow  = 4'd0;
	localparam logic [3:0] PadTempHigh = 4'd1;
	localparam logic [3:0] PadConfig   = 4'd4;

	// Number of ROM bytes stored ahead of the CRC byte.
	localparam int RomBytes = 7;

	// Sixteenths of a degree to ten-thousandths of a degree.
	localparam logic [25:0] TempScale = 26'd625;

	typedef enum logic {
		KIND_ROM = 1'b0,
		KIND_PAD = 1'b1
	} frame_kind_t;

	typedef logic [7:0] byte_t;

	// One byte of CRC, least significant bit first.
	function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
		byte_t crc;
		byte_t b;
		crc = crc_in;
		b   = data;
		for (int k = 0; k < 8; k++) begin
			if ((crc[0] ^ b[0]) == 1'b1) begin
				crc = (crc >> 1) ^ CrcPoly;
			end else begin
				crc = crc >> 1;
			end
			b = b >> 1;
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

[hdl/sensor_frame_crc_temp_decode.sv]
`default_nettype none

// Channel   Valid          Stall          Payload
// byte      byte_valid     byte_stall     mode, first_byte, data_byte
// result    result_valid   result_stall   frame_kind, status, family_code,
//                                         serial_number, temperature, resolution_bits
//
// One beat is taken per cycle while byte_stall is low. An accepted byte lands in an
// input register, and the CRC step, frame bookkeeping and the temperature multiply
// are then done by one level of logic that loads the result register, so the last
// byte of a frame passes through the input register and then the result register.
// Reset clears the frame position, the running CRC and both valid flags.
// A byte that ends a frame waits in the input register while the result register is
// still held by result_stall; byte_stall rises only then. Other bytes pass freely.
module sensor_frame_crc_temp_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire logic                mode,
	input  wire logic                first_byte,
	input  wire sfcrc_pkg::byte_t    data_byte,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic                     frame_kind,
	output logic                     status,
	output logic [7:0]               family_code,
	output logic [47:0]              serial_number,
	output logic signed [25:0]       temperature,
	output logic [1:0]               resolution_bits
);
	import sfcrc_pkg::*;

	// Input register.
	logic        valid_s1;
	logic        mode_s1;
	logic        first_s1;
	byte_t       data_s1;

	// Frame state.
	byte_t       crc_q;
	logic [3:0]  idx_q;
	frame_kind_t mode_q;
	byte_t       temp_low_q;
	byte_t       temp_high_q;
	byte_t       config_q;
	byte_t       rom_q [RomBytes];

	// Frame step for the byte in the input register.
	logic        restart;
	logic [3:0]  idx_eff;
	byte_t       crc_eff;
	frame_kind_t mode_eff;
	logic [3:0]  last_idx;
	logic        is_last;
	logic        out_ready;
	logic        advance;
	logic        accept;
	logic [25:0] temp_prod;

	assign restart  = first_s1 || (idx_q == 4'd0);
	assign idx_eff  = restart ? 4'd0 : idx_q;
	assign crc_eff  = restart ? 8'd0 : crc_q;
	assign mode_eff = restart ? frame_kind_t'(mode_s1) : mode_q;
	assign last_idx = (mode_eff == KIND_PAD) ? PadLast : RomLast;
	assign is_last  = (idx_eff >= last_idx);

	// The result register frees up in the same cycle that its beat is taken.
	assign out_ready  = !result_valid || !result_stall;
	assign advance    = valid_s1 && (!is_last || out_ready);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	// Raw temperature is signed sixteenths; the low 26 bits of the product are exact.
	assign temp_prod = {{10{temp_high_q[7]}}, temp_high_q, temp_low_q} * TempScale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			first_s1 <= first_byte;
			data_s1  <= data_byte;
		end
	end

	// Position, CRC and latched frame kind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			idx_q  <= '0;
			mode_q <= KIND_ROM;
		end else if (advance) begin
			mode_q <= mode_eff;
			if (is_last) begin
				crc_q <= '0;
				idx_q <= '0;
			end else begin
				crc_q <= crc8_byte(crc_eff, data_s1);
				idx_q <= idx_eff + 4'd1;
			end
		end
	end

	// Kept frame bytes. Limit and reserved scratchpad bytes only feed the CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= '0;
			temp_high_q <= '0;
			config_q    <= '0;
			for (int i = 0; i < RomBytes; i++) begin
				rom_q[i] <= '0;
			end
		end else if (advance && !is_last) begin
			if (mode_eff == KIND_PAD) begin
				if (idx_eff == PadTempLow) begin
					temp_low_q <= data_s1;
				end else if (idx_eff == PadTempHigh) begin
					temp_high_q <= data_s1;
				end else if (idx_eff == PadConfig) begin
					config_q <= data_s1;
				end
			end else begin
				rom_q[idx_eff[2:0]] <= data_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && is_last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			frame_kind <= mode_eff;
			status     <= (crc_eff != data_s1);
			if (mode_eff == KIND_PAD) begin
				family_code     <= '0;
				serial_number   <= '0;
				temperature     <= $signed(temp_prod);
				resolution_bits <= config_q[6:5];
			end else begin
				family_code     <= rom_q[0];
				serial_number   <= {rom_q[6], rom_q[5], rom_q[4], rom_q[3],
				                    rom_q[2], rom_q[1]};
				temperature     <= '0;
				resolution_bits <= '0;
			end
		end
	end

	// A new result appears only from a frame-ending byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(advance && is_last))
		else $error("result raised without a frame end");

	// The position never runs past the CRC byte of a scratchpad.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= PadLast)
		else $error("byte position beyond scratchpad length");

	// In an address frame the position stays within the ROM bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == KIND_ROM) |-> (idx_q <= RomLast))
		else $error("byte position beyond ROM length");

	// A frame end blocked by a held result stays in the input register untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_last && result_valid && result_stall)
		|=> (valid_s1 && $stable(data_s1) && $stable(idx_q) && $stable(crc_q)))
		else $error("blocked frame end was lost or changed");

	// Stall toward the byte side comes only from a waiting frame end.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && is_last && result_valid))
		else $error("byte stall without a blocked frame end");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfcrc_pkg::*;

	// A run stops when neither channel moves a beat for this many cycles. The longest
	// legal quiet stretch is the receiver hold-off plus a sender gap, far below this.
	localparam int WatchdogLimit = 1000;
	// Receiver hold-off used to fill the block and push stall back onto the bytes.
	localparam int HoldOffCycles = 120;
	// Number of random input beats.
	localparam int RandomBeats = 540;
	// Cycles to linger after the last expected result, enough to catch a late extra one.
	localparam int DrainCycles = 10;

	// Receiver behaviors for result_stall.
	typedef enum int {
		RX_READY,
		RX_PATTERN,
		RX_RANDOM
	} rx_style_t;

	// One decoded frame as the result channel should show it.
	typedef struct packed {
		frame_kind_t  kind;
		logic         crc_bad;
		byte_t        family;
		logic [47:0]  serial;
		logic [25:0]  temp;
		logic [1:0]   res;
	} frame_decode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Byte channel, driven by the sender.
	logic byte_valid = 1'b0;
	logic mode = 1'b0;
	logic first_byte = 1'b0;
	byte_t data_byte = '0;
	logic byte_stall;

	// Result channel, stalled by the receiver process below.
	logic result_stall = 1'b0;
	logic result_valid;
	logic frame_kind;
	logic status;
	logic [7:0] family_code;
	logic [47:0] serial_number;
	logic signed [25:0] temperature;
	logic [1:0] resolution_bits;

	// Decodes predicted for frames that have ended but whose result has not yet left.
	frame_decode_t decodes_due[$];
	int mismatch_count = 0;
	int beats_sent = 0;

	// Frame tracker state, kept in step with every byte beat the block accepts.
	byte_t crc_so_far = '0;
	logic [3:0] next_pos = '0;
	frame_kind_t latched_kind = KIND_ROM;
	byte_t pad_temp_lo = '0;
	byte_t pad_temp_hi = '0;
	byte_t pad_cfg = '0;
	logic [55:0] rom_image = '0;

	// Sender pacing: when enabled, beats come in bursts separated by idle gaps.
	bit pace_gaps = 1'b0;
	int burst_left = 0;

	// Receiver control. A test posts a hold-off length; the receiver process owns the count.
	rx_style_t rx_style = RX_READY;
	int holdoff_req = 0;
	int holdoff_left = 0;
	int rx_cycle = 0;

	sensor_frame_crc_temp_decode u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.mode            (mode),
		.first_byte      (first_byte),
		.data_byte       (data_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.frame_kind      (frame_kind),
		.status          (status),
		.family_code     (family_code),
		.serial_number   (serial_number),
		.temperature     (temperature),
		.resolution_bits (resolution_bits)
	);

	always #2 clk = ~clk;

	// Reflected CRC-8 step: the register bit leaving at the bottom, XORed with the data
	// bit, decides whether the shifted register is folded with the polynomial.
	function automatic byte_t crc8_next(input byte_t acc, input byte_t d);
		byte_t c;
		logic fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = {1'b0, c[7:1]};
			if (fb) begin
				c = c ^ CrcPoly;
			end
		end
		return c;
	endfunction

	// Advances the frame tracker by one accepted byte. A byte that ends a frame turns
	// the collected fields into one predicted decode; every other byte yields nothing.
	task automatic track_frame_byte(input logic m, input logic f, input byte_t d);
		logic [3:0] last_pos;
		frame_decode_t r;
		logic signed [15:0] raw;
		int scaled;
		// A restart flag, or a position back at zero, opens a new frame and latches its kind.
		if (f || next_pos == 4'd0) begin
			next_pos = 4'd0;
			crc_so_far = '0;
			latched_kind = frame_kind_t'(m);
		end
		last_pos = (latched_kind == KIND_PAD) ? PadLast : RomLast;
		if (next_pos < last_pos) begin
			if (latched_kind == KIND_PAD) begin
				if (next_pos == PadTempLow) begin
					pad_temp_lo = d;
				end else if (next_pos == PadTempHigh) begin
					pad_temp_hi = d;
				end else if (next_pos == PadConfig) begin
					pad_cfg = d;
				end
			end else begin
				rom_image[8*next_pos +: 8] = d;
			end
			crc_so_far = crc8_next(crc_so_far, d);
			next_pos = next_pos + 4'd1;
		end else begin
			r = '0;
			r.kind = latched_kind;
			r.crc_bad = (crc_so_far != d);
			if (latched_kind == KIND_PAD) begin
				// The raw reading is two's complement in sixteenths of a degree.
				raw = {pad_temp_hi, pad_temp_lo};
				scaled = int'(raw) * int'(TempScale);
				r.temp = scaled[25:0];
				r.res = pad_cfg[6:5];
			end else begin
				r.family = rom_image[7:0];
				r.serial = rom_image[55:8];
			end
			decodes_due.push_back(r);
			next_pos = 4'd0;
			crc_so_far = '0;
		end
	endtask

	// Offers one byte beat and returns in the time step in which it was accepted. The
	// payload is held steady while byte_stall is high. With pacing on, a burst that has
	// run out is followed by an idle gap before the next beat is offered.
	task automatic send_byte(input logic m, input logic f, input byte_t d);
		int gap;
		if (pace_gaps && burst_left == 0) begin
			byte_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		byte_valid <= 1'b1;
		mode <= m;
		first_byte <= f;
		data_byte <= d;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		track_frame_byte(m, f, d);
		beats_sent++;
	endtask

	// Sends a frame built from its body (every byte ahead of the CRC). The CRC byte is
	// computed here and, when asked, spoiled by a nonzero pattern. Only the first `keep`
	// bytes go out, so a short count leaves a frame cut off. Byte zero carries the
	// restart flag whenever a partial frame is pending; otherwise it carries start_flag.
	// Mode is random on every later byte, since the block must ignore it there.
	task automatic send_frame(input frame_kind_t kind, input byte_t body[8], input logic corrupt,
			input int keep, input logic start_flag);
		int len;
		byte_t crc;
		byte_t b;
		logic f;
		logic m;
		len = (kind == KIND_PAD) ? int'(PadLast) + 1 : int'(RomLast) + 1;
		crc = '0;
		for (int i = 0; i < len - 1; i++) begin
			crc = crc8_next(crc, body[i]);
		end
		if (corrupt) begin
			crc = crc ^ byte_t'($urandom_range(1, 255));
		end
		for (int i = 0; i < len && i < keep; i++) begin
			b = (i == len - 1) ? crc : body[i];
			if (i == 0) begin
				f = (next_pos != 4'd0) ? 1'b1 : start_flag;
				m = kind;
			end else begin
				f = 1'b0;
				m = 1'($urandom_range(0, 1));
			end
			send_byte(m, f, b);
		end
	endtask

	// A ROM address: family code zero and a serial of all ones, with a good CRC.
	task automatic test_rom_decode();
		byte_t body[8];
		body = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_frame(KIND_ROM, body, 1'b0, 8, 1'b1);
	endtask

	// Two bytes of a ROM frame are dropped by a restart into a scratchpad that holds
	// the coldest raw value and the highest resolution setting, sent with a bad CRC.
	task automatic test_restart_mid_frame();
		byte_t body[8];
		send_byte(KIND_ROM, 1'b1, 8'h28);
		send_byte(KIND_ROM, 1'b0, 8'hA5);
		body = '{8'h00, 8'h80, 8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10};
		send_frame(KIND_PAD, body, 1'b1, 9, 1'b1);
	endtask

	// Right after a finished frame, a new one starts without the restart flag. It holds
	// the warmest raw value and a configuration byte with both resolution bits clear.
	task automatic test_frame_after_frame();
		byte_t body[8];
		body = '{8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h1F, 8'h00, 8'hFF, 8'h00};
		send_frame(KIND_PAD, body, 1'b0, 9, 1'b0);
	endtask

	// Random frame body. Scratchpads now and then carry the temperature extremes or the values either side of zero.
	task automatic random_body(input frame_kind_t kind, output byte_t body[8]);
		logic [15:0] raw;
		for (int i = 0; i < 8; i++) begin
			body[i] = byte_t'($urandom_range(0, 255));
		end
		if (kind == KIND_PAD && $urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0: raw = 16'h7FFF;
				1: raw = 16'h8000;
				2: raw = 16'h0000;
				default: raw = 16'hFFFF;
			endcase
			body[0] = raw[7:0];
			body[1] = raw[15:8];
		end
	endtask

	// The receiver holds off for a long stretch while whole frames keep coming with no
	// sender gaps, so the result register and the input register both fill and the
	// block must stall the byte channel until the hold-off ends.
	task automatic test_backpressure();
		byte_t body[8];
		frame_kind_t kind;
		pace_gaps = 1'b0;
		holdoff_req = HoldOffCycles;
		for (int n = 0; n < 4; n++) begin
			kind = frame_kind_t'($urandom_range(0, 1));
			random_body(kind, body);
			send_frame(kind, body, 1'b0, 9, 1'b1);
		end
	endtask

	// Mostly well-formed frames with random content and an occasional bad CRC; the
	// rest is cut-off frames and loose noise bytes with random flags. Pacing on both
	// sides changes every so often so gaps land on every position in a frame.
	task automatic test_random_traffic();
		byte_t body[8];
		frame_kind_t kind;
		int start;
		int pick;
		int round;
		start = beats_sent;
		round = 0;
		while (beats_sent - start < RandomBeats) begin
			if (round % 12 == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 2));
				pace_gaps = ($urandom_range(0, 3) != 0);
			end
			round++;
			pick = $urandom_range(0, 9);
			kind = frame_kind_t'($urandom_range(0, 1));
			if (pick == 0) begin
				repeat ($urandom_range(1, 5)) begin
					send_byte(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
						byte_t'($urandom_range(0, 255)));
				end
			end else if (pick == 1) begin
				random_body(kind, body);
				send_frame(kind, body, 1'b0, $urandom_range(1, 7),
					1'($urandom_range(0, 1)));
			end else begin
				random_body(kind, body);
				send_frame(kind, body, ($urandom_range(0, 4) == 0), 9,
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Receiver: a posted hold-off wins; otherwise result_stall follows the chosen style.
	always @(posedge clk) begin
		rx_cycle++;
		if (holdoff_req != 0) begin
			holdoff_left = holdoff_req;
			holdoff_req = 0;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			result_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_PATTERN: result_stall <= ((rx_cycle % 9) < 3);
				RX_RANDOM: result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= 1'b0;
			endcase
		end
	end

	// Result checker: each accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		frame_decode_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (decodes_due.size() == 0) begin
				$error("result beat with no frame pending: kind %0d status %0d",
					frame_kind, status);
				mismatch_count++;
			end else begin
				exp_r = decodes_due.pop_front();
				if (frame_kind !== exp_r.kind) begin
					$error("frame_kind: expected %0d, actual %0d", exp_r.kind, frame_kind);
					mismatch_count++;
				end
				if (status !== exp_r.crc_bad) begin
					$error("status: expected %0d, actual %0d", exp_r.crc_bad, status);
					mismatch_count++;
				end
				if (family_code !== exp_r.family) begin
					$error("family_code: expected %h, actual %h", exp_r.family, family_code);
					mismatch_count++;
				end
				if (serial_number !== exp_r.serial) begin
					$error("serial_number: expected %h, actual %h", exp_r.serial,
						serial_number);
					mismatch_count++;
				end
				if (temperature !== exp_r.temp) begin
					$error("temperature: expected %0d, actual %0d", $signed(exp_r.temp),
						temperature);
					mismatch_count++;
				end
				if (resolution_bits !== exp_r.res) begin
					$error("resolution_bits: expected %0d, actual %0d", exp_r.res,
						resolution_bits);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any beat on either channel resets the quiet count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames run with both sides always ready.
		test_rom_decode();
		test_restart_mid_frame();
		test_frame_after_frame();
		test_backpressure();
		test_random_traffic();

		// Let everything drain with the receiver always ready, then linger a little so a
		// stray extra result would still be seen by the checker.
		byte_valid <= 1'b0;
		rx_style = RX_READY;
		while (decodes_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0 && decodes_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
